>>> hdl/assert_macros.svh
// Assertion macros used by the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define PLC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// An expression that must never be true.
`define PLC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `PLC_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

>>> hdl/plc_pkg.sv
// Shared types and constants for the positional list with cursor.
`default_nettype none
package plc_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;
    localparam int REQ_W     = 5;
    localparam int POS_W     = 8;
    localparam int STAT_W    = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR        = 5'd0,
        REQ_READ_CUR     = 5'd1,
        REQ_READ_AT      = 5'd2,
        REQ_FIRST        = 5'd3,
        REQ_LAST         = 5'd4,
        REQ_GOTO         = 5'd5,
        REQ_ADVANCE      = 5'd6,
        REQ_RETREAT      = 5'd7,
        REQ_INS_FRONT    = 5'd8,
        REQ_INS_END      = 5'd9,
        REQ_INS_BEFORE   = 5'd10,
        REQ_INS_AFTER    = 5'd11,
        REQ_INS_AT       = 5'd12,
        REQ_DEL_FRONT    = 5'd13,
        REQ_DEL_END      = 5'd14,
        REQ_DEL_CUR      = 5'd15,
        REQ_DEL_BEFORE   = 5'd16,
        REQ_DEL_AFTER    = 5'd17,
        REQ_DEL_AT       = 5'd18,
        REQ_REP_FRONT    = 5'd19,
        REQ_REP_END      = 5'd20,
        REQ_REP_CUR      = 5'd21,
        REQ_REP_BEFORE   = 5'd22,
        REQ_REP_AFTER    = 5'd23,
        REQ_REP_AT       = 5'd24
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_NOTRAV  = 3'd1,
        STAT_BADPOS  = 3'd2,
        STAT_NONEXT  = 3'd3,
        STAT_NOPREV  = 3'd4,
        STAT_EMPTY   = 3'd5,
        STAT_FULL    = 3'd6
    } stat_t;

    typedef enum logic [2:0] {
        K_NONE,
        K_READ,
        K_WRITE,
        K_INSERT,
        K_DELETE
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SH_RD,
        S_SH_WR,
        S_FIN_WR,
        S_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sh_rd;
        logic sh_wr;
        logic fin_wr;
        logic load_out;
    } plc_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  shift;
        logic  last;
        logic  ins;
        logic  out_free;
    } plc_sts_t;

endpackage
`default_nettype wire

>>> hdl/plc_datapath.sv
// Datapath: request latch, decode, list storage, shift walker and result register.
`default_nettype none
module plc_datapath
    import plc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire plc_cmd_t          cmd,
    output plc_sts_t               sts,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [POS_W-1:0]  s_pos,
    input  wire logic [WIDTH-1:0]  s_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [STAT_W-1:0]      m_status,
    output logic [WIDTH-1:0]       m_read_value,
    output logic [CW-1:0]          m_list_size,
    output logic [CW-1:0]          m_cursor_pos
);

    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C  = CW'(1);

    logic [WIDTH-1:0] mem [DEPTH];

    req_t             req_reg;
    logic [POS_W-1:0] pos_reg;
    logic [WIDTH-1:0] value_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    cursor_reg, cursor_next;
    logic [AW-1:0]    tgt_reg, ptr_reg, end_reg;
    kind_t            kind_reg;
    stat_t            status_reg;
    logic             ins_reg;
    logic [WIDTH-1:0] rdata_reg;
    logic             m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [WIDTH-1:0] m_read_value_reg;
    logic [CW-1:0]    m_list_size_reg, m_cursor_pos_reg;

    stat_t         st;
    kind_t         kind;
    logic [CW-1:0] tpos;
    logic [AW-1:0] tidx;
    logic [PW-1:0] pe, ne;
    logic          pos_bad, pos_bad_ins, no_trav, full, empty;
    logic          shift;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [WIDTH-1:0] wdata;

    assign pe          = PW'(pos_reg);
    assign ne          = PW'(count_reg);
    assign pos_bad     = (pe == '0) || (pe > ne);
    assign pos_bad_ins = (pe == '0) || (pe > ne + PW'(1));
    assign no_trav     = (cursor_reg == '0);
    assign full        = (count_reg >= FULL_C);
    assign empty       = (count_reg == '0);

    // Request decode against the current size and cursor.
    always_comb begin
        st          = STAT_OK;
        kind        = K_NONE;
        tpos        = ONE_C;
        count_next  = count_reg;
        cursor_next = cursor_reg;
        unique case (req_reg)
            REQ_CLEAR: begin
                count_next  = '0;
                cursor_next = '0;
            end
            REQ_READ_CUR: begin
                if (no_trav) st = STAT_NOTRAV;
                else begin kind = K_READ; tpos = cursor_reg; end
            end
            REQ_READ_AT: begin
                if (pos_bad) st = STAT_BADPOS;
                else begin kind = K_READ; tpos = CW'(pos_reg); end
            end
            REQ_FIRST:  cursor_next = empty ? '0 : ONE_C;
            REQ_LAST:   cursor_next = count_reg;
            REQ_GOTO: begin
                if (pos_bad) st = STAT_BADPOS;
                else cursor_next = CW'(pos_reg);
            end
            REQ_ADVANCE: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (cursor_reg >= count_reg) cursor_next = '0;
                else cursor_next = cursor_reg + ONE_C;
            end
            REQ_RETREAT: begin
                if (no_trav) st = STAT_NOTRAV;
                else cursor_next = cursor_reg - ONE_C;
            end
            REQ_INS_FRONT: begin
                if (full) st = STAT_FULL;
                else begin
                    kind = K_INSERT; tpos = ONE_C;
                    if (!no_trav) cursor_next = cursor_reg + ONE_C;
                end
            end
            REQ_INS_END: begin
                if (full) st = STAT_FULL;
                else begin kind = K_INSERT; tpos = count_reg + ONE_C; end
            end
            REQ_INS_BEFORE: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (full) st = STAT_FULL;
                else begin
                    kind = K_INSERT; tpos = cursor_reg;
                    cursor_next = cursor_reg + ONE_C;
                end
            end
            REQ_INS_AFTER: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (full) st = STAT_FULL;
                else begin kind = K_INSERT; tpos = cursor_reg + ONE_C; end
            end
            REQ_INS_AT: begin
                if (pos_bad_ins) st = STAT_BADPOS;
                else if (full) st = STAT_FULL;
                else begin
                    kind = K_INSERT; tpos = CW'(pos_reg);
                    if (PW'(cursor_reg) >= pe) cursor_next = cursor_reg + ONE_C;
                end
            end
            REQ_DEL_FRONT: begin
                if (empty) st = STAT_BADPOS;
                else begin
                    kind = K_DELETE; tpos = ONE_C;
                    if (cursor_reg == ONE_C) cursor_next = '0;
                    else if (cursor_reg > ONE_C) cursor_next = cursor_reg - ONE_C;
                end
            end
            REQ_DEL_END: begin
                if (empty) st = STAT_BADPOS;
                else begin
                    kind = K_DELETE; tpos = count_reg;
                    if (cursor_reg == count_reg) cursor_next = '0;
                end
            end
            REQ_DEL_CUR: begin
                if (no_trav) st = STAT_NOTRAV;
                else begin
                    kind = K_DELETE; tpos = cursor_reg;
                    if (cursor_reg == count_reg) cursor_next = '0;
                end
            end
            REQ_DEL_BEFORE: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (cursor_reg == ONE_C) st = STAT_NOPREV;
                else begin
                    kind = K_DELETE; tpos = cursor_reg - ONE_C;
                    cursor_next = cursor_reg - ONE_C;
                end
            end
            REQ_DEL_AFTER: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (cursor_reg >= count_reg) st = STAT_NONEXT;
                else begin kind = K_DELETE; tpos = cursor_reg + ONE_C; end
            end
            REQ_DEL_AT: begin
                if (pos_bad) st = STAT_BADPOS;
                else begin
                    kind = K_DELETE; tpos = CW'(pos_reg);
                    if (!no_trav && PW'(cursor_reg) == pe) begin
                        if (cursor_reg == count_reg) cursor_next = '0;
                    end else if (PW'(cursor_reg) > pe) begin
                        cursor_next = cursor_reg - ONE_C;
                    end
                end
            end
            REQ_REP_FRONT: begin
                if (empty) st = STAT_EMPTY;
                else begin kind = K_WRITE; tpos = ONE_C; end
            end
            REQ_REP_END: begin
                if (empty) st = STAT_EMPTY;
                else begin kind = K_WRITE; tpos = count_reg; end
            end
            REQ_REP_CUR: begin
                if (no_trav) st = STAT_NOTRAV;
                else begin kind = K_WRITE; tpos = cursor_reg; end
            end
            REQ_REP_BEFORE: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (cursor_reg == ONE_C) st = STAT_NOPREV;
                else begin kind = K_WRITE; tpos = cursor_reg - ONE_C; end
            end
            REQ_REP_AFTER: begin
                if (no_trav) st = STAT_NOTRAV;
                else if (cursor_reg >= count_reg) st = STAT_NONEXT;
                else begin kind = K_WRITE; tpos = cursor_reg + ONE_C; end
            end
            REQ_REP_AT: begin
                if (pos_bad) st = STAT_BADPOS;
                else begin kind = K_WRITE; tpos = CW'(pos_reg); end
            end
            default: ;
        endcase
        if (kind == K_INSERT) count_next = count_reg + ONE_C;
        if (kind == K_DELETE) count_next = count_reg - ONE_C;
    end

    assign tidx  = AW'(tpos - ONE_C);
    assign shift = ((kind == K_INSERT) && (tpos <= count_reg)) ||
                   ((kind == K_DELETE) && (tpos < count_reg));

    assign sts.kind     = kind;
    assign sts.shift    = shift;
    assign sts.last     = (ptr_reg == end_reg);
    assign sts.ins      = ins_reg;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign rd_addr = cmd.exec ? tidx : ptr_reg;
    assign we      = cmd.sh_wr || cmd.fin_wr;
    assign waddr   = cmd.fin_wr ? tgt_reg : (ins_reg ? ptr_reg + AW'(1) : ptr_reg - AW'(1));
    assign wdata   = cmd.fin_wr ? value_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        if (cmd.exec || cmd.sh_rd) rdata_reg <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg   <= req_t'(s_req_type);
            pos_reg   <= s_pos;
            value_reg <= s_value;
        end
        if (cmd.exec) begin
            kind_reg   <= kind;
            status_reg <= st;
            tgt_reg    <= tidx;
            ins_reg    <= (kind == K_INSERT);
            ptr_reg    <= (kind == K_INSERT) ? AW'(count_reg - ONE_C) : AW'(tpos);
            end_reg    <= (kind == K_INSERT) ? tidx : AW'(count_reg - ONE_C);
        end else if (cmd.sh_wr) begin
            ptr_reg <= ins_reg ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
        end
        if (cmd.load_out) begin
            m_status_reg     <= status_reg;
            m_read_value_reg <= (kind_reg == K_READ) ? rdata_reg : '0;
            m_list_size_reg  <= count_reg;
            m_cursor_pos_reg <= cursor_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
            if (cmd.load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;
    assign m_list_size  = m_list_size_reg;
    assign m_cursor_pos = m_cursor_pos_reg;

endmodule
`default_nettype wire

>>> hdl/plc_ctrl.sv
// Controller state machine sequencing decode, element shifts and the result.
`default_nettype none
module plc_ctrl
    import plc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire plc_sts_t sts,
    output plc_cmd_t      cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_EXEC;
            S_EXEC: begin
                if (sts.shift) state_next = S_SH_RD;
                else if (sts.kind == K_INSERT || sts.kind == K_WRITE) state_next = S_FIN_WR;
                else state_next = S_RESP;
            end
            S_SH_RD: state_next = S_SH_WR;
            S_SH_WR: begin
                if (!sts.last) state_next = S_SH_RD;
                else if (sts.ins) state_next = S_FIN_WR;
                else state_next = S_RESP;
            end
            S_FIN_WR: state_next = S_RESP;
            S_RESP: if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = (state_reg == S_IDLE);
        cmd.accept   = (state_reg == S_IDLE) && s_valid;
        cmd.exec     = (state_reg == S_EXEC);
        cmd.sh_rd    = (state_reg == S_SH_RD);
        cmd.sh_wr    = (state_reg == S_SH_WR);
        cmd.fin_wr   = (state_reg == S_FIN_WR);
        cmd.load_out = (state_reg == S_RESP) && sts.out_free;
    end

endmodule
`default_nettype wire

>>> hdl/positional_list_with_cursor.sv
// Top level of the bounded positional list with cursor.
//
//   Channel  Direction  Ports
//   request  in         s_valid, s_ready, s_req_type, s_pos, s_value
//   result   out        m_valid, m_ready, m_status, m_read_value, m_list_size, m_cursor_pos
//
// A request passes through decode and then to the result register; replaces and inserts
// also pass through a final element write, and inserts and deletes that move elements
// run a shift loop that moves one element per read/write pair.
// Reset clears the size, the cursor and the controller; element storage is not cleared.
// A waiting result holds in the output register while the next request is accepted;
// only the completion of that next request waits for the result to be taken.
`default_nettype none
module positional_list_with_cursor
    import plc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [REQ_W-1:0]  s_req_type,
    input  wire logic [POS_W-1:0]  s_pos,
    input  wire logic [WIDTH-1:0]  s_value,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [STAT_W-1:0]      m_status,
    output logic [WIDTH-1:0]       m_read_value,
    output logic [CW-1:0]          m_list_size,
    output logic [CW-1:0]          m_cursor_pos
);

    // Commands flow from the controller to the datapath, status flows back.
    plc_cmd_t cmd;
    plc_sts_t sts;

    // The controller steps each request through decode, the element shift loop,
    // the final element write and the hand-off to the result register.
    plc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the element memory, size, cursor and result register.
    plc_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_req_type   (s_req_type),
        .s_pos        (s_pos),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value),
        .m_list_size  (m_list_size),
        .m_cursor_pos (m_cursor_pos)
    );

endmodule
`default_nettype wire

>>> hdl/plc_checker.sv
// Port-level checker for the positional list, with its bind statement.
`default_nettype none
`include "assert_macros.svh"
module plc_checker
    import plc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [STAT_W-1:0] m_status,
    input wire logic [WIDTH-1:0]  m_read_value,
    input wire logic [CW-1:0]     m_list_size,
    input wire logic [CW-1:0]     m_cursor_pos
);

    `PLC_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_status), "result dropped while stalled")
    `PLC_ASSERT_NEVER(a_cursor, aclk, aresetn, m_valid && (m_cursor_pos > m_list_size), "cursor beyond list size")
    `PLC_ASSERT_NEVER(a_size, aclk, aresetn, m_valid && (m_list_size > CW'(DEPTH)), "list size beyond depth")
    `PLC_ASSERT_NEVER(a_rdzero, aclk, aresetn, m_valid && (m_status != STAT_OK) && (m_read_value != '0), "read data on failed request")

endmodule

bind positional_list_with_cursor plc_checker #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
) u_plc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value),
    .m_list_size  (m_list_size),
    .m_cursor_pos (m_cursor_pos)
);
`default_nettype wire
